/* rtl/core/qvr_pkg.sv */
// shared types, widths and register codes for the quaternion vector rotate core
package qvr_pkg;

   localparam int QVR_QUAT_WIDTH  = 16;
   localparam int QVR_VEC_WIDTH   = 24;
   localparam int QVR_QUAT_FRAC   = 14;
   localparam int QVR_CSR_IDX_W   = 2;

   // register index codes
   localparam logic [QVR_CSR_IDX_W-1:0] CSR_QUAT_X = 2'd0;
   localparam logic [QVR_CSR_IDX_W-1:0] CSR_QUAT_Y = 2'd1;
   localparam logic [QVR_CSR_IDX_W-1:0] CSR_QUAT_Z = 2'd2;
   localparam logic [QVR_CSR_IDX_W-1:0] CSR_QUAT_W = 2'd3;

   // identity rotation, 1.0 in q2.14
   localparam logic [QVR_QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

   typedef struct packed {
      logic signed [QVR_QUAT_WIDTH-1:0] x;
      logic signed [QVR_QUAT_WIDTH-1:0] y;
      logic signed [QVR_QUAT_WIDTH-1:0] z;
      logic signed [QVR_QUAT_WIDTH-1:0] w;
   } quat_type;

   typedef struct packed {
      logic valid;
      logic inv;
   } beat_ctl_type;

   // width of the first product components t
   function automatic int qvr_t_width(input int vec_w);
      return vec_w + QVR_QUAT_WIDTH + 2;
   endfunction

   // width of the second product sums, wide enough for the rounding shift and range check
   function automatic int qvr_sum_width(input int vec_w, input int frac);
      int a;
      int b;
      a = qvr_t_width(vec_w) + QVR_QUAT_WIDTH + 1 + 3;
      b = 2 * frac + vec_w + 1;
      return (a > b) ? a : b;
   endfunction

endpackage

/* rtl/core/qvr_first_prod.sv */
// stages one and two: q*p or conj(q)*p kept at full precision, plus the second-pass quaternion
module qvr_first_prod import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   localparam int TW = qvr_t_width(VEC_WIDTH),
   localparam int BW = QVR_QUAT_WIDTH + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  beat_ctl_type                in_ctl,
   input  logic signed [VEC_WIDTH-1:0] vec_x,
   input  logic signed [VEC_WIDTH-1:0] vec_y,
   input  logic signed [VEC_WIDTH-1:0] vec_z,
   input  quat_type                    quat,
   output logic                        out_valid,
   output logic signed [TW-1:0]        t_x,
   output logic signed [TW-1:0]        t_y,
   output logic signed [TW-1:0]        t_z,
   output logic signed [TW-1:0]        t_w,
   output logic signed [BW-1:0]        b_x,
   output logic signed [BW-1:0]        b_y,
   output logic signed [BW-1:0]        b_z,
   output logic signed [BW-1:0]        b_w
);

   localparam int QW = QVR_QUAT_WIDTH;
   localparam int PW = VEC_WIDTH + QW;

   logic signed [QW-1:0] qx, qy, qz, qw;

   logic signed [PW-1:0] wpx_in, wpy_in, wpz_in, ypz_in, zpy_in, zpx_in;
   logic signed [PW-1:0] xpz_in, xpy_in, ypx_in, xpx_in, ypy_in, zpz_in;
   logic signed [PW-1:0] wpx_ff, wpy_ff, wpz_ff, ypz_ff, zpy_ff, zpx_ff;
   logic signed [PW-1:0] xpz_ff, xpy_ff, ypx_ff, xpx_ff, ypy_ff, zpz_ff;
   logic                 s1_valid_ff, s1_inv_ff;

   logic signed [TW-1:0] cross_x, cross_y, cross_z, dot;
   logic signed [TW-1:0] t_x_in, t_y_in, t_z_in, t_w_in;
   logic signed [TW-1:0] t_x_ff, t_y_ff, t_z_ff, t_w_ff;
   logic signed [BW-1:0] b_x_in, b_y_in, b_z_in, b_w_in;
   logic signed [BW-1:0] b_x_ff, b_y_ff, b_z_ff, b_w_ff;
   logic                 s2_valid_ff;

   assign qx = $signed(quat.x);
   assign qy = $signed(quat.y);
   assign qz = $signed(quat.z);
   assign qw = $signed(quat.w);

   // stage one: all twelve partial products of q and p
   assign wpx_in = qw * vec_x;
   assign wpy_in = qw * vec_y;
   assign wpz_in = qw * vec_z;
   assign ypz_in = qy * vec_z;
   assign zpy_in = qz * vec_y;
   assign zpx_in = qz * vec_x;
   assign xpz_in = qx * vec_z;
   assign xpy_in = qx * vec_y;
   assign ypx_in = qy * vec_x;
   assign xpx_in = qx * vec_x;
   assign ypy_in = qy * vec_y;
   assign zpz_in = qz * vec_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_inv_ff <= in_ctl.inv;
         wpx_ff    <= wpx_in;
         wpy_ff    <= wpy_in;
         wpz_ff    <= wpz_in;
         ypz_ff    <= ypz_in;
         zpy_ff    <= zpy_in;
         zpx_ff    <= zpx_in;
         xpz_ff    <= xpz_in;
         xpy_ff    <= xpy_in;
         ypx_ff    <= ypx_in;
         xpx_ff    <= xpx_in;
         ypy_ff    <= ypy_in;
         zpz_ff    <= zpz_in;
      end
   end

   // stage two: the inverse flips the cross term and the scalar part
   assign cross_x = TW'(ypz_ff) - TW'(zpy_ff);
   assign cross_y = TW'(zpx_ff) - TW'(xpz_ff);
   assign cross_z = TW'(xpy_ff) - TW'(ypx_ff);
   assign dot     = TW'(xpx_ff) + TW'(ypy_ff) + TW'(zpz_ff);

   assign t_x_in = TW'(wpx_ff) + (s1_inv_ff ? -cross_x : cross_x);
   assign t_y_in = TW'(wpy_ff) + (s1_inv_ff ? -cross_y : cross_y);
   assign t_z_in = TW'(wpz_ff) + (s1_inv_ff ? -cross_z : cross_z);
   assign t_w_in = s1_inv_ff ? dot : -dot;

   // second multiplicand: conj(q) forward, q inverse; one extra bit for negated minimum
   assign b_x_in = s1_inv_ff ? BW'(qx) : -BW'(qx);
   assign b_y_in = s1_inv_ff ? BW'(qy) : -BW'(qy);
   assign b_z_in = s1_inv_ff ? BW'(qz) : -BW'(qz);
   assign b_w_in = BW'(qw);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_x_ff <= t_x_in;
         t_y_ff <= t_y_in;
         t_z_ff <= t_z_in;
         t_w_ff <= t_w_in;
         b_x_ff <= b_x_in;
         b_y_ff <= b_y_in;
         b_z_ff <= b_z_in;
         b_w_ff <= b_w_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign t_x = t_x_ff;
   assign t_y = t_y_ff;
   assign t_z = t_z_ff;
   assign t_w = t_w_ff;
   assign b_x = b_x_ff;
   assign b_y = b_y_ff;
   assign b_z = b_z_ff;
   assign b_w = b_w_ff;

endmodule

/* rtl/core/qvr_second_prod.sv */
// stages three and four: second quaternion product and rounded sums
module qvr_second_prod import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   parameter int QUAT_FRAC = QVR_QUAT_FRAC,
   localparam int TW = qvr_t_width(VEC_WIDTH),
   localparam int BW = QVR_QUAT_WIDTH + 1,
   localparam int SW = qvr_sum_width(VEC_WIDTH, QUAT_FRAC)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [TW-1:0] t_x,
   input  logic signed [TW-1:0] t_y,
   input  logic signed [TW-1:0] t_z,
   input  logic signed [TW-1:0] t_w,
   input  logic signed [BW-1:0] b_x,
   input  logic signed [BW-1:0] b_y,
   input  logic signed [BW-1:0] b_z,
   input  logic signed [BW-1:0] b_w,
   output logic                 out_valid,
   output logic signed [SW-1:0] sum_x,
   output logic signed [SW-1:0] sum_y,
   output logic signed [SW-1:0] sum_z
);

   localparam int PW = TW + BW;
   // half an lsb of the result, so the shift rounds to nearest with ties upward
   localparam logic [SW-1:0] RND = SW'(1) << (2 * QUAT_FRAC - 1);

   logic signed [PW-1:0] tybz_in, tzby_in, twbx_in, txbw_in;
   logic signed [PW-1:0] tzbx_in, txbz_in, twby_in, tybw_in;
   logic signed [PW-1:0] txby_in, tybx_in, twbz_in, tzbw_in;
   logic signed [PW-1:0] tybz_ff, tzby_ff, twbx_ff, txbw_ff;
   logic signed [PW-1:0] tzbx_ff, txbz_ff, twby_ff, tybw_ff;
   logic signed [PW-1:0] txby_ff, tybx_ff, twbz_ff, tzbw_ff;
   logic                 s3_valid_ff;

   logic signed [SW-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic signed [SW-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic                 s4_valid_ff;

   assign tybz_in = t_y * b_z;
   assign tzby_in = t_z * b_y;
   assign twbx_in = t_w * b_x;
   assign txbw_in = t_x * b_w;
   assign tzbx_in = t_z * b_x;
   assign txbz_in = t_x * b_z;
   assign twby_in = t_w * b_y;
   assign tybw_in = t_y * b_w;
   assign txby_in = t_x * b_y;
   assign tybx_in = t_y * b_x;
   assign twbz_in = t_w * b_z;
   assign tzbw_in = t_z * b_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tybz_ff <= tybz_in;
         tzby_ff <= tzby_in;
         twbx_ff <= twbx_in;
         txbw_ff <= txbw_in;
         tzbx_ff <= tzbx_in;
         txbz_ff <= txbz_in;
         twby_ff <= twby_in;
         tybw_ff <= tybw_in;
         txby_ff <= txby_in;
         tybx_ff <= tybx_in;
         twbz_ff <= twbz_in;
         tzbw_ff <= tzbw_in;
      end
   end

   assign sum_x_in = SW'(tybz_ff) - SW'(tzby_ff) + SW'(twbx_ff) + SW'(txbw_ff) + $signed(RND);
   assign sum_y_in = SW'(tzbx_ff) - SW'(txbz_ff) + SW'(twby_ff) + SW'(tybw_ff) + $signed(RND);
   assign sum_z_in = SW'(txby_ff) - SW'(tybx_ff) + SW'(twbz_ff) + SW'(tzbw_ff) + $signed(RND);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign sum_x = sum_x_ff;
   assign sum_y = sum_y_ff;
   assign sum_z = sum_z_ff;

endmodule

/* rtl/core/qvr_round_sat.sv */
// stage five: fraction drop, saturation and the output register
module qvr_round_sat import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   parameter int QUAT_FRAC = QVR_QUAT_FRAC,
   localparam int SW = qvr_sum_width(VEC_WIDTH, QUAT_FRAC)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [SW-1:0]        sum_x,
   input  logic signed [SW-1:0]        sum_y,
   input  logic signed [SW-1:0]        sum_z,
   output logic                        out_valid,
   output logic signed [VEC_WIDTH-1:0] out_x,
   output logic signed [VEC_WIDTH-1:0] out_y,
   output logic signed [VEC_WIDTH-1:0] out_z,
   output logic                        saturated
);

   localparam int LSB = 2 * QUAT_FRAC;
   localparam int HW  = SW - LSB - VEC_WIDTH + 1;

   // clip flag on top, component below
   function automatic logic [VEC_WIDTH:0] sat_one(input logic signed [SW-1:0] s);
      logic [HW-1:0] hi;
      hi = s[SW-1:LSB+VEC_WIDTH-1];
      if (hi == '0 || hi == '1) begin
         return {1'b0, s[LSB+VEC_WIDTH-1:LSB]};
      end else if (s[SW-1]) begin
         return {2'b11, {(VEC_WIDTH-1){1'b0}}};
      end else begin
         return {2'b10, {(VEC_WIDTH-1){1'b1}}};
      end
   endfunction

   logic [VEC_WIDTH:0]          sat_x, sat_y, sat_z;
   logic                        s5_valid_ff;
   logic signed [VEC_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                        sat_in, sat_ff;

   assign sat_x  = sat_one(sum_x);
   assign sat_y  = sat_one(sum_y);
   assign sat_z  = sat_one(sum_z);
   assign sat_in = sat_x[VEC_WIDTH] | sat_y[VEC_WIDTH] | sat_z[VEC_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= $signed(sat_x[VEC_WIDTH-1:0]);
         out_y_ff <= $signed(sat_y[VEC_WIDTH-1:0]);
         out_z_ff <= $signed(sat_z[VEC_WIDTH-1:0]);
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;
   assign saturated = sat_ff;

endmodule

/* rtl/core/quaternion_vector_rotate_core.sv */
// top level of the quaternion vector rotate core: register file, pipeline and handshake
//
// rotates a stream of 3d vectors by the quaternion held in four registers
// csr channel: csr_wr_en, csr_index, csr_wdata write quat_x, quat_y, quat_z, quat_w
//   (signed q2.14) at a rising edge; write only while no beat is in flight
// req channel: a beat is taken when req_valid is high and req_stall is low;
//   req_cmd 0 gives q*p*conj(q), 1 gives conj(q)*p*q
// rsp channel: out_x/y/z are saturated to the input width, rsp_saturated flags a clip;
//   a beat leaves when rsp_valid is high and rsp_stall is low
// stages: five register stages: q*p products, t sums, t*b products, rounded sums,
//   saturate/output
// throughput: one beat per cycle unless stalled; the q*p stage holds a 16 x 24 product
//   row and the t*b stage a 42 x 17 product row
// stall: when the output register holds a beat and rsp_stall is high, every stage
//   freezes and req_stall goes high in the same cycle, so nothing is lost or repeated
// reset: clears all stage valid bits and loads the identity quaternion (w = 1.0)
module quaternion_vector_rotate_core import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   parameter int QUAT_FRAC = QVR_QUAT_FRAC
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [QVR_CSR_IDX_W-1:0]    csr_index,
   input  logic [QVR_QUAT_WIDTH-1:0]   csr_wdata,
   // request beats
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic signed [VEC_WIDTH-1:0] req_vec_x,
   input  logic signed [VEC_WIDTH-1:0] req_vec_y,
   input  logic signed [VEC_WIDTH-1:0] req_vec_z,
   // response beats
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [VEC_WIDTH-1:0] rsp_out_x,
   output logic signed [VEC_WIDTH-1:0] rsp_out_y,
   output logic signed [VEC_WIDTH-1:0] rsp_out_z,
   output logic                        rsp_saturated
);

   localparam int TW = qvr_t_width(VEC_WIDTH);
   localparam int BW = QVR_QUAT_WIDTH + 1;
   localparam int SW = qvr_sum_width(VEC_WIDTH, QUAT_FRAC);

   quat_type     quat_ff, quat_in;
   beat_ctl_type req_ctl;
   logic         en;

   logic                 p2_valid;
   logic signed [TW-1:0] t_x, t_y, t_z, t_w;
   logic signed [BW-1:0] b_x, b_y, b_z, b_w;

   logic                 p4_valid;
   logic signed [SW-1:0] sum_x, sum_y, sum_z;

   // quaternion registers
   always_comb begin
      quat_in = quat_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUAT_X: quat_in.x = $signed(csr_wdata);
            CSR_QUAT_Y: quat_in.y = $signed(csr_wdata);
            CSR_QUAT_Z: quat_in.z = $signed(csr_wdata);
            CSR_QUAT_W: quat_in.w = $signed(csr_wdata);
            default:    quat_in   = quat_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
         quat_ff.w <= $signed(QUAT_W_RESET);
      end else begin
         quat_ff <= quat_in;
      end
   end

   // whole pipe moves unless a finished beat sits waiting on the receiver
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   assign req_ctl.valid = req_valid;
   assign req_ctl.inv   = req_cmd;

   qvr_first_prod #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_first (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (req_ctl),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_z     (req_vec_z),
      .quat      (quat_ff),
      .out_valid (p2_valid),
      .t_x       (t_x),
      .t_y       (t_y),
      .t_z       (t_z),
      .t_w       (t_w),
      .b_x       (b_x),
      .b_y       (b_y),
      .b_z       (b_z),
      .b_w       (b_w)
   );

   qvr_second_prod #(
      .VEC_WIDTH (VEC_WIDTH),
      .QUAT_FRAC (QUAT_FRAC)
   ) u_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid),
      .t_x       (t_x),
      .t_y       (t_y),
      .t_z       (t_z),
      .t_w       (t_w),
      .b_x       (b_x),
      .b_y       (b_y),
      .b_z       (b_z),
      .b_w       (b_w),
      .out_valid (p4_valid),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_z     (sum_z)
   );

   qvr_round_sat #(
      .VEC_WIDTH (VEC_WIDTH),
      .QUAT_FRAC (QUAT_FRAC)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p4_valid),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_z     (sum_z),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .saturated (rsp_saturated)
   );

endmodule
